// ===== src/drmp_pkg.sv =====
// Shared types and constants for the dwell-return motion profile generator.
package drmp_pkg;

    localparam int REG_W = 24;
    localparam int PH_W  = 26;
    localparam int SUM_W = 27;
    localparam int POS_W = 25;
    localparam int IDX_W = 3;
    localparam int DT_W  = 16;

    typedef logic signed [REG_W-1:0] t_coord;
    typedef logic [1:0]              t_seg;

    localparam t_seg SEG_RISE   = 2'd0;
    localparam t_seg SEG_TARGET = 2'd1;
    localparam t_seg SEG_RETURN = 2'd2;
    localparam t_seg SEG_ORIGIN = 2'd3;

    localparam logic [IDX_W-1:0] CFG_TRAVEL   = 3'd0;
    localparam logic [IDX_W-1:0] CFG_PAUSE    = 3'd1;
    localparam logic [IDX_W-1:0] CFG_ORIGIN_X = 3'd2;
    localparam logic [IDX_W-1:0] CFG_ORIGIN_Y = 3'd3;
    localparam logic [IDX_W-1:0] CFG_ORIGIN_Z = 3'd4;
    localparam logic [IDX_W-1:0] CFG_OFFSET_X = 3'd5;
    localparam logic [IDX_W-1:0] CFG_OFFSET_Y = 3'd6;
    localparam logic [IDX_W-1:0] CFG_OFFSET_Z = 3'd7;

endpackage

// ===== src/drmp_divstep.sv =====
// One restoring shift-subtract step shared by the modulo and the alpha division.
module drmp_divstep import drmp_pkg::*; (
    input  logic [PH_W-1:0] i_rem,
    input  logic [PH_W-1:0] i_div,
    input  logic            i_bit,
    output logic [PH_W-1:0] o_rem,
    output logic            o_q
);

    logic [PH_W:0] w_trial;
    logic [PH_W:0] w_diff;

    assign w_trial = {i_rem, i_bit};
    assign w_diff  = w_trial - {1'b0, i_div};
    assign o_q     = (w_trial >= {1'b0, i_div});
    assign o_rem   = o_q ? w_diff[PH_W-1:0] : w_trial[PH_W-1:0];

endmodule

// ===== src/drmp_mul.sv =====
// Registered signed offset by unsigned alpha multiplier, shared by the three axes in turn.
module drmp_mul import drmp_pkg::*; #(
    parameter int ALPHA_BITS = 16
) (
    input  logic                                 i_clk,
    input  t_coord                               i_a,
    input  logic [ALPHA_BITS:0]                  i_b,
    output logic signed [REG_W+ALPHA_BITS+1:0]   o_p
);

    logic signed [REG_W+ALPHA_BITS+1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * $signed({1'b0, i_b});
    end

    assign o_p = r_p;

endmodule

// ===== src/dwell_return_motion_profile.sv =====
// Dwell-return motion profile generator: phase, segment, alpha and per-axis position.
// Each accepted item runs the serial modulo (27 steps) and, in the moving segments only, the
// serial alpha division (ALPHA_BITS steps) on the shared subtract unit; the dwell segments
// skip the division. One item is in work at a time: no new item is taken until the result
// has gone to the output, which waits while the output stalls. Synchronous active-low reset
// clears the configuration registers, phase and control state.
module dwell_return_motion_profile import drmp_pkg::*; #(
    parameter int ALPHA_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [IDX_W-1:0]        i_cfg_index,
    input  logic [REG_W-1:0]        i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [DT_W-1:0]         i_delta_time,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [POS_W-1:0] o_pos_x,
    output logic signed [POS_W-1:0] o_pos_y,
    output logic signed [POS_W-1:0] o_pos_z,
    output logic [1:0]              o_segment
);

    localparam int AW     = ALPHA_BITS + 1;
    localparam int PW     = REG_W + ALPHA_BITS + 2;
    localparam int CntMax = (SUM_W > ALPHA_BITS) ? SUM_W : ALPHA_BITS;
    localparam int CntW   = $clog2(CntMax);
    localparam logic [AW-1:0] AlphaOne = {1'b1, {ALPHA_BITS{1'b0}}};

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_SEG  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [REG_W-1:0]        r_travel;
    logic [REG_W-1:0]        r_pause;
    t_coord                  r_org [3];
    t_coord                  r_off [3];
    logic [PH_W-1:0]         r_phase;
    logic [2:0]              r_state;
    logic [CntW-1:0]         r_cnt;
    logic [SUM_W-1:0]        r_num;
    logic [PH_W-1:0]         r_rem;
    logic [ALPHA_BITS-1:0]   r_quot;
    logic [AW-1:0]           r_alpha;
    t_seg                    r_seg;
    logic signed [POS_W-1:0] r_pos [3];
    logic                    r_o_valid;
    logic signed [POS_W-1:0] r_o_pos_x;
    logic signed [POS_W-1:0] r_o_pos_y;
    logic signed [POS_W-1:0] r_o_pos_z;
    t_seg                    r_o_seg;

    logic [REG_W:0]          w_tp;
    logic [PH_W-1:0]         w_cycle;
    logic [PH_W-1:0]         w_end_ret;
    logic                    w_cyc_zero;
    logic                    w_lt_t;
    logic                    w_lt_tp;
    logic                    w_lt_ret;
    logic [PH_W-1:0]         w_ret;
    logic [PH_W-1:0]         w_ds_div;
    logic                    w_ds_bit;
    logic [PH_W-1:0]         w_ds_rem;
    logic                    w_ds_q;
    logic [ALPHA_BITS-1:0]   w_quot_n;
    logic                    w_out_free;
    t_coord                  w_mul_a;
    t_coord                  w_org_sel;
    logic signed [PW-1:0]    w_prod;
    logic signed [PW-1:0]    w_prod_sh;
    logic signed [POS_W-1:0] w_pos;

    assign w_tp       = {1'b0, r_travel} + {1'b0, r_pause};
    assign w_cycle    = {w_tp, 1'b0};
    assign w_end_ret  = {1'b0, w_tp} + {2'b00, r_travel};
    assign w_cyc_zero = (r_travel == '0) && (r_pause == '0);
    assign w_lt_t     = r_rem < {2'b00, r_travel};
    assign w_lt_tp    = r_rem < {1'b0, w_tp};
    assign w_lt_ret   = r_rem < w_end_ret;
    assign w_ret      = r_rem - {1'b0, w_tp};

    assign w_ds_div = (r_state == S_MOD) ? w_cycle : {2'b00, r_travel};
    assign w_ds_bit = (r_state == S_MOD) ? r_num[SUM_W-1] : 1'b0;

    drmp_divstep u_divstep (
        .i_rem (r_rem),
        .i_div (w_ds_div),
        .i_bit (w_ds_bit),
        .o_rem (w_ds_rem),
        .o_q   (w_ds_q)
    );

    assign w_quot_n = {r_quot[ALPHA_BITS-2:0], w_ds_q};

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    w_mul_a = r_off[0];
            2'd1:    w_mul_a = r_off[1];
            default: w_mul_a = r_off[2];
        endcase
    end

    always_comb begin
        case (r_cnt[1:0])
            2'd1:    w_org_sel = r_org[0];
            2'd2:    w_org_sel = r_org[1];
            default: w_org_sel = r_org[2];
        endcase
    end

    drmp_mul #(
        .ALPHA_BITS (ALPHA_BITS)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (r_alpha),
        .o_p   (w_prod)
    );

    assign w_prod_sh  = w_prod >>> ALPHA_BITS;
    assign w_pos      = w_prod_sh[POS_W-1:0] + {w_org_sel[REG_W-1], w_org_sel};
    assign w_out_free = !r_o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
            r_phase   <= '0;
            r_travel  <= '0;
            r_pause   <= '0;
            r_org[0]  <= '0;
            r_org[1]  <= '0;
            r_org[2]  <= '0;
            r_off[0]  <= '0;
            r_off[1]  <= '0;
            r_off[2]  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TRAVEL:   r_travel <= i_cfg_data;
                    CFG_PAUSE:    r_pause  <= i_cfg_data;
                    CFG_ORIGIN_X: r_org[0] <= i_cfg_data;
                    CFG_ORIGIN_Y: r_org[1] <= i_cfg_data;
                    CFG_ORIGIN_Z: r_org[2] <= i_cfg_data;
                    CFG_OFFSET_X: r_off[0] <= i_cfg_data;
                    CFG_OFFSET_Y: r_off[1] <= i_cfg_data;
                    CFG_OFFSET_Z: r_off[2] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_o_valid && !i_stall && (r_state != S_OUT)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (i_valid && !w_cyc_zero) begin
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (r_cnt == CntW'(SUM_W - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_SEG;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_SEG: begin
                    r_phase <= r_rem;
                    r_cnt   <= '0;
                    if (w_lt_t || (!w_lt_tp && w_lt_ret)) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_DIV: begin
                    if (r_cnt == CntW'(ALPHA_BITS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_MUL;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_MUL: begin
                    if (r_cnt == CntW'(3)) begin
                        r_cnt   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_o_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_num <= {1'b0, r_phase} + SUM_W'(i_delta_time);
                r_rem <= '0;
            end
            S_MOD: begin
                r_num <= {r_num[SUM_W-2:0], 1'b0};
                r_rem <= w_ds_rem;
            end
            S_SEG: begin
                if (w_lt_t) begin
                    r_seg <= SEG_RISE;
                end else if (w_lt_tp) begin
                    r_seg   <= SEG_TARGET;
                    r_alpha <= AlphaOne;
                end else if (w_lt_ret) begin
                    r_seg <= SEG_RETURN;
                    r_rem <= w_ret;
                end else begin
                    r_seg   <= SEG_ORIGIN;
                    r_alpha <= '0;
                end
            end
            S_DIV: begin
                r_rem  <= w_ds_rem;
                r_quot <= w_quot_n;
                if (r_cnt == CntW'(ALPHA_BITS - 1)) begin
                    if (r_seg == SEG_RISE) begin
                        r_alpha <= {1'b0, w_quot_n};
                    end else begin
                        r_alpha <= AlphaOne - {1'b0, w_quot_n};
                    end
                end
            end
            S_MUL: begin
                case (r_cnt[1:0])
                    2'd1:    r_pos[0] <= w_pos;
                    2'd2:    r_pos[1] <= w_pos;
                    2'd3:    r_pos[2] <= w_pos;
                    default: ;
                endcase
            end
            S_OUT: begin
                if (w_out_free) begin
                    r_o_pos_x <= r_pos[0];
                    r_o_pos_y <= r_pos[1];
                    r_o_pos_z <= r_pos[2];
                    r_o_seg   <= r_seg;
                end
            end
            default: ;
        endcase
    end

    assign o_stall   = (r_state != S_IDLE);
    assign o_valid   = r_o_valid;
    assign o_pos_x   = r_o_pos_x;
    assign o_pos_y   = r_o_pos_y;
    assign o_pos_z   = r_o_pos_z;
    assign o_segment = r_o_seg;

`ifndef SYNTH
    a_zero_cycle_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid && w_cyc_zero) |=> (r_state == S_IDLE))
        else $error("item with zero cycle started work");
    a_accept_starts_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid && !w_cyc_zero) |=> (r_state == S_MOD))
        else $error("accepted item did not start the modulo");
    a_phase_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEG) |-> (r_rem < w_cycle))
        else $error("reduced phase not below the cycle");
    a_alpha_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_alpha <= AlphaOne))
        else $error("alpha above one");
    a_origin_dwell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_seg == SEG_ORIGIN) |-> (r_o_pos_x == {r_org[0][REG_W-1], r_org[0]}))
        else $error("origin dwell result differs from origin");
`endif

endmodule
